/* rtl/i2cm_pkg.sv */
package i2cm_pkg;

   localparam int unsigned FUNC_W   = 3;
   localparam int unsigned BYTE_W   = 8;
   localparam int unsigned REQ_DW   = 16;
   localparam int unsigned RSP_DW   = 16;
   localparam int unsigned BCOUNT_W = 3;
   localparam int unsigned QUART_W  = 2;

   localparam logic [BCOUNT_W-1:0] BIT_LAST = 3'd7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_TICK      = 3'd0,
      FUNC_START     = 3'd1,
      FUNC_WRITE     = 3'd2,
      FUNC_READ_ACK  = 3'd3,
      FUNC_READ_NACK = 3'd4,
      FUNC_STOP      = 3'd5
   } func_type;

   typedef enum logic [10:0] {
      ST_IDLE = 11'b000_0000_0001,
      ST_SA   = 11'b000_0000_0010,
      ST_SB   = 11'b000_0000_0100,
      ST_SC   = 11'b000_0000_1000,
      ST_PA   = 11'b000_0001_0000,
      ST_PB   = 11'b000_0010_0000,
      ST_PC   = 11'b000_0100_0000,
      ST_WBIT = 11'b000_1000_0000,
      ST_WACK = 11'b001_0000_0000,
      ST_RBIT = 11'b010_0000_0000,
      ST_RACK = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [BYTE_W-1:0] tx_data;
      logic              scl_in;
      logic              sda_in;
   } item_type;

   typedef struct packed {
      logic              scl_release;
      logic              sda_release;
      logic              busy_res;
      logic              done_res;
      logic [BYTE_W-1:0] rx_data;
      logic              ack_seen;
   } result_type;

endpackage

/* rtl/i2cm_core.sv */
module i2cm_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  i2cm_pkg::item_type   item,
   output i2cm_pkg::result_type result
);

   i2cm_pkg::state_type                  state_ff, state_in, cur_state;
   logic [i2cm_pkg::QUART_W-1:0]         quarter_ff, quarter_in, cur_quarter;
   logic [i2cm_pkg::BCOUNT_W-1:0]        bit_count_ff, bit_count_in, cur_bit_count;
   logic [i2cm_pkg::BYTE_W-1:0]          shift_ff, shift_in, cur_shift;
   logic                                 nack_ff, nack_in, cur_nack;
   logic                                 ack_ff, ack_in;
   logic                                 scl_ff, scl_in;
   logic                                 sda_ff, sda_in;
   logic [i2cm_pkg::BYTE_W-1:0]          rx_ff, rx_in;
   logic                                 done;
   logic                                 byte_state;

   // command decode, taken only when idle
   always_comb begin
      cur_state     = state_ff;
      cur_quarter   = quarter_ff;
      cur_bit_count = bit_count_ff;
      cur_shift     = shift_ff;
      cur_nack      = nack_ff;
      if (state_ff == i2cm_pkg::ST_IDLE) begin
         case (i2cm_pkg::func_type'(item.func))
            i2cm_pkg::FUNC_START: begin
               cur_state = i2cm_pkg::ST_SA;
            end
            i2cm_pkg::FUNC_WRITE: begin
               cur_state     = i2cm_pkg::ST_WBIT;
               cur_quarter   = '0;
               cur_bit_count = '0;
               cur_shift     = item.tx_data;
            end
            i2cm_pkg::FUNC_READ_ACK: begin
               cur_state     = i2cm_pkg::ST_RBIT;
               cur_quarter   = '0;
               cur_bit_count = '0;
               cur_shift     = '0;
               cur_nack      = 1'b0;
            end
            i2cm_pkg::FUNC_READ_NACK: begin
               cur_state     = i2cm_pkg::ST_RBIT;
               cur_quarter   = '0;
               cur_bit_count = '0;
               cur_shift     = '0;
               cur_nack      = 1'b1;
            end
            i2cm_pkg::FUNC_STOP: begin
               cur_state = i2cm_pkg::ST_PA;
            end
            default: begin
               cur_state = state_ff;
            end
         endcase
      end
   end

   // one bus quarter
   always_comb begin
      state_in     = cur_state;
      quarter_in   = cur_quarter;
      bit_count_in = cur_bit_count;
      shift_in     = cur_shift;
      nack_in      = cur_nack;
      ack_in       = ack_ff;
      scl_in       = scl_ff;
      sda_in       = sda_ff;
      rx_in        = rx_ff;
      done         = 1'b0;
      byte_state   = 1'b0;
      case (cur_state)
         i2cm_pkg::ST_IDLE: begin
            state_in = i2cm_pkg::ST_IDLE;
         end
         i2cm_pkg::ST_SA: begin
            scl_in   = 1'b1;
            sda_in   = 1'b1;
            state_in = i2cm_pkg::ST_SB;
         end
         i2cm_pkg::ST_SB: begin
            if (item.scl_in) begin
               sda_in   = 1'b0;
               state_in = i2cm_pkg::ST_SC;
            end
         end
         i2cm_pkg::ST_SC: begin
            scl_in   = 1'b0;
            state_in = i2cm_pkg::ST_IDLE;
            done     = 1'b1;
         end
         i2cm_pkg::ST_PA: begin
            scl_in   = 1'b0;
            sda_in   = 1'b0;
            state_in = i2cm_pkg::ST_PB;
         end
         i2cm_pkg::ST_PB: begin
            scl_in   = 1'b1;
            state_in = i2cm_pkg::ST_PC;
         end
         i2cm_pkg::ST_PC: begin
            if (item.scl_in) begin
               sda_in   = 1'b1;
               state_in = i2cm_pkg::ST_IDLE;
               done     = 1'b1;
            end
         end
         i2cm_pkg::ST_WBIT, i2cm_pkg::ST_WACK, i2cm_pkg::ST_RBIT, i2cm_pkg::ST_RACK: begin
            byte_state = 1'b1;
         end
         default: begin
            state_in = i2cm_pkg::ST_IDLE;
         end
      endcase

      if (byte_state) begin
         case (cur_quarter)
            2'd0: begin
               scl_in = 1'b0;
               if (cur_state == i2cm_pkg::ST_WBIT) begin
                  sda_in = cur_shift[i2cm_pkg::BYTE_W-1];
               end else if (cur_state == i2cm_pkg::ST_RACK) begin
                  sda_in = cur_nack;
               end else begin
                  sda_in = 1'b1;
               end
               quarter_in = cur_quarter + 2'd1;
            end
            2'd1: begin
               scl_in     = 1'b1;
               quarter_in = cur_quarter + 2'd1;
            end
            2'd2: begin
               if (item.scl_in) begin
                  if (cur_state == i2cm_pkg::ST_WACK) begin
                     ack_in = ~item.sda_in;
                  end
                  if (cur_state == i2cm_pkg::ST_RBIT) begin
                     shift_in = {cur_shift[i2cm_pkg::BYTE_W-2:0], item.sda_in};
                  end
                  quarter_in = cur_quarter + 2'd1;
               end
            end
            default: begin
               scl_in     = 1'b0;
               quarter_in = '0;
               if (cur_state == i2cm_pkg::ST_WBIT || cur_state == i2cm_pkg::ST_RBIT) begin
                  if (cur_bit_count == i2cm_pkg::BIT_LAST) begin
                     bit_count_in = '0;
                     state_in     = (cur_state == i2cm_pkg::ST_WBIT) ?
                                    i2cm_pkg::ST_WACK : i2cm_pkg::ST_RACK;
                  end else begin
                     bit_count_in = cur_bit_count + 3'd1;
                     if (cur_state == i2cm_pkg::ST_WBIT) begin
                        shift_in = {cur_shift[i2cm_pkg::BYTE_W-2:0], 1'b0};
                     end
                  end
               end else begin
                  if (cur_state == i2cm_pkg::ST_RACK) begin
                     rx_in = cur_shift;
                  end
                  state_in = i2cm_pkg::ST_IDLE;
                  done     = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= i2cm_pkg::ST_IDLE;
         quarter_ff   <= '0;
         bit_count_ff <= '0;
         shift_ff     <= '0;
         nack_ff      <= 1'b0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rx_ff        <= '0;
      end else if (fire) begin
         state_ff     <= state_in;
         quarter_ff   <= quarter_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         nack_ff      <= nack_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
         rx_ff        <= rx_in;
      end
   end

   always_comb begin
      result.scl_release = scl_in;
      result.sda_release = sda_in;
      result.busy_res    = (state_in != i2cm_pkg::ST_IDLE);
      result.done_res    = done;
      result.rx_data     = rx_in;
      result.ack_seen    = ack_in;
   end

`ifndef SYNTHESIS
   a_bitcount_in_data: assert property (@(posedge clock) disable iff (reset)
      (bit_count_ff != '0) |-> (state_ff == i2cm_pkg::ST_WBIT || state_ff == i2cm_pkg::ST_RBIT))
      else $error("bit count set outside data bits");

   a_quarter_in_byte: assert property (@(posedge clock) disable iff (reset)
      (quarter_ff != '0) |-> (state_ff == i2cm_pkg::ST_WBIT || state_ff == i2cm_pkg::ST_WACK ||
                              state_ff == i2cm_pkg::ST_RBIT || state_ff == i2cm_pkg::ST_RACK))
      else $error("quarter count set outside byte transfer");

   a_start_stretch: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff == i2cm_pkg::ST_SB && !item.scl_in) |=> (state_ff == i2cm_pkg::ST_SB))
      else $error("start left wait while scl held low");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      (fire && result.done_res) |=> (state_ff == i2cm_pkg::ST_IDLE))
      else $error("done without return to idle");

   a_idle_scl_low_after_start: assert property (@(posedge clock) disable iff (reset)
      (fire && state_ff == i2cm_pkg::ST_SC) |=> (!scl_ff && !sda_ff))
      else $error("start condition left lines in wrong state");
`endif

endmodule

/* rtl/i2c_master_byte_engine.sv */
// channel | dir | tdata (low bit up)                                 | tuser
// req     | in  | tx_data[7:0], scl_in, sda_in, pad                  | func[2:0]
// rsp     | out | scl_release, sda_release, busy_res, done_res,      | -
//         |     | rx_data[7:0], ack_seen, pad                        |
// one beat in, one beat out; a beat per cycle sustained while rsp is not stalled
// registered path: input register, then bus step into the output register
// reset is synchronous and leaves both lines released and the engine idle
// a stall on rsp holds the output register and the input register behind it
module i2c_master_byte_engine (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [i2cm_pkg::REQ_DW-1:0]   req_tdata,  // tx_data, scl_in, sda_in
   input  logic [i2cm_pkg::FUNC_W-1:0]   req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [i2cm_pkg::RSP_DW-1:0]   rsp_tdata   // scl, sda, busy, done, rx_data, ack
);

   logic                   in_valid_ff, in_valid_in;
   i2cm_pkg::item_type      in_item_ff;
   logic                   out_valid_ff, out_valid_in;
   i2cm_pkg::result_type    out_res_ff;
   i2cm_pkg::result_type    step_res;
   logic                   out_free;
   logic                   fire;
   logic                   req_fire;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign fire       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_fire   = req_tvalid && req_tready;

   assign in_valid_in  = req_fire || (in_valid_ff && !fire);
   assign out_valid_in = fire || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.func    <= req_tuser;
         in_item_ff.tx_data <= req_tdata[7:0];
         in_item_ff.scl_in  <= req_tdata[8];
         in_item_ff.sda_in  <= req_tdata[9];
      end
      if (fire) begin
         out_res_ff <= step_res;
      end
   end

   i2cm_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (in_item_ff),
      .result (step_res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000,
                        out_res_ff.ack_seen,
                        out_res_ff.rx_data,
                        out_res_ff.done_res,
                        out_res_ff.busy_res,
                        out_res_ff.sda_release,
                        out_res_ff.scl_release};

endmodule
